>>> src/pce_pkg.sv
// Package for the Playfair encryptor: key-square constants, item modes,
// controller states and the command/status structs between ctrl and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pce_pkg;

    localparam logic [4:0] C_CELLS       = 5'd25;
    localparam logic [4:0] C_LAST_LETTER = 5'd25;
    localparam logic [2:0] C_SIDE_LAST   = 3'd4;
    localparam logic [4:0] C_IDX_I       = 5'd8;
    localparam logic [4:0] C_IDX_J       = 5'd9;
    localparam logic [4:0] C_IDX_X       = 5'd23;
    localparam logic [6:0] C_CHAR_A      = 7'd65;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_SEAL  = 2'd1,
        MODE_TEXT  = 2'd2,
        MODE_FLUSH = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEAL,
        ST_POS,
        ST_SQ,
        ST_OUT_FIRST,
        ST_OUT_SECOND
    } t_state;

    typedef struct packed {
        logic take;
        logic seal_step;
        logic rd_pos;
        logic rd_sq;
        logic out_second;
    } t_cmd;

    typedef struct packed {
        logic go_seal;
        logic go_enc;
        logic seal_last;
    } t_stat;

endpackage

`default_nettype wire

>>> src/pce_ifs.sv
// Valid/ready channel interfaces for the Playfair encryptor: input item
// channel and cipher letter channel. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pce_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, mode, data_byte, input ready);
    modport sink   (input valid, mode, data_byte, output ready);
endinterface

interface pce_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_char;
    logic       pair_last;

    modport source (output valid, cipher_char, pair_last, input ready);
    modport sink   (input valid, cipher_char, pair_last, output ready);
endinterface

`default_nettype wire

>>> src/pce_datapath.sv
// Datapath of the Playfair encryptor: key square and letter position memories,
// present bits, fill/seal/pending state, pair lookup and cell rules.
// Depends on pce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pce_datapath (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire pce_pkg::t_cmd i_cmd,
    output pce_pkg::t_stat   o_stat,
    input  wire [1:0]        i_mode,
    input  wire [7:0]        i_data_byte,
    output logic [6:0]       o_cipher_char,
    output logic             o_pair_last
);

    logic [4:0] sq_mem  [25];
    logic [4:0] pos_mem [26];

    logic [25:0] r_present;
    logic [4:0]  r_fill;
    logic        r_sealed;
    logic [4:0]  r_seal_idx;
    logic [4:0]  r_pend;
    logic        r_pend_v;
    logic [4:0]  r_pa, r_pb;
    logic [4:0]  r_pos_a, r_pos_b;
    logic [4:0]  r_ch_a, r_ch_b;

    pce_pkg::t_mode w_mode;
    logic [7:0] w_diff_u, w_diff_l;
    logic       w_is_letter;
    logic [4:0] w_letter;
    logic       w_place_req;
    logic [4:0] w_place_l;
    logic       w_place_do;
    logic       w_text_pair;
    logic       w_flush_pair;
    logic [4:0] w_o1, w_o2;

    function automatic logic [4:0] f_map_j(input logic [4:0] l);
        f_map_j = (l == pce_pkg::C_IDX_J) ? pce_pkg::C_IDX_I : l;
    endfunction

    function automatic logic [2:0] f_row(input logic [4:0] p);
        if (p < 5'd5)       f_row = 3'd0;
        else if (p < 5'd10) f_row = 3'd1;
        else if (p < 5'd15) f_row = 3'd2;
        else if (p < 5'd20) f_row = 3'd3;
        else                f_row = 3'd4;
    endfunction

    function automatic logic [4:0] f_mul5(input logic [2:0] r);
        f_mul5 = {r, 2'b00} + {2'b00, r};
    endfunction

    function automatic logic [2:0] f_inc(input logic [2:0] v);
        f_inc = (v == pce_pkg::C_SIDE_LAST) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [2:0] f_col(input logic [4:0] p);
        logic [4:0] d;
        d = p - f_mul5(f_row(p));
        f_col = d[2:0];
    endfunction

    // byte decode
    always_comb begin
        w_mode      = pce_pkg::t_mode'(i_mode);
        w_diff_u    = i_data_byte - 8'd65;
        w_diff_l    = i_data_byte - 8'd97;
        w_is_letter = 1'b0;
        w_letter    = 5'd0;
        if (i_data_byte inside {[8'd65:8'd90]}) begin
            w_is_letter = 1'b1;
            w_letter    = w_diff_u[4:0];
        end else if (i_data_byte inside {[8'd97:8'd122]}) begin
            w_is_letter = 1'b1;
            w_letter    = w_diff_l[4:0];
        end
    end

    // placement from key byte or seal sweep
    always_comb begin
        w_place_req = 1'b0;
        w_place_l   = 5'd0;
        if (i_cmd.take && w_mode == pce_pkg::MODE_KEY && !r_sealed && w_is_letter) begin
            w_place_req = 1'b1;
            w_place_l   = f_map_j(w_letter);
        end else if (i_cmd.seal_step && r_seal_idx != pce_pkg::C_IDX_J) begin
            w_place_req = 1'b1;
            w_place_l   = r_seal_idx;
        end
        w_place_do = w_place_req && !r_present[w_place_l] && (r_fill < pce_pkg::C_CELLS);
    end

    always_comb begin
        w_text_pair  = (w_mode == pce_pkg::MODE_TEXT) && r_sealed && w_is_letter && r_pend_v;
        w_flush_pair = (w_mode == pce_pkg::MODE_FLUSH) && r_sealed && r_pend_v;
        o_stat.go_seal   = (w_mode == pce_pkg::MODE_SEAL) && !r_sealed;
        o_stat.go_enc    = w_text_pair || w_flush_pair;
        o_stat.seal_last = (r_seal_idx == pce_pkg::C_LAST_LETTER);
    end

    // row, column and rectangle rules
    always_comb begin
        logic [2:0] r1, c1, r2, c2;
        r1 = f_row(r_pos_a);
        c1 = f_col(r_pos_a);
        r2 = f_row(r_pos_b);
        c2 = f_col(r_pos_b);
        if (r1 == r2) begin
            w_o1 = f_mul5(r1) + {2'b00, f_inc(c1)};
            w_o2 = f_mul5(r2) + {2'b00, f_inc(c2)};
        end else if (c1 == c2) begin
            w_o1 = f_mul5(f_inc(r1)) + {2'b00, c1};
            w_o2 = f_mul5(f_inc(r2)) + {2'b00, c2};
        end else begin
            w_o1 = f_mul5(r1) + {2'b00, c2};
            w_o2 = f_mul5(r2) + {2'b00, c1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_place_do) begin
            pos_mem[w_place_l] <= r_fill;
            sq_mem[r_fill]     <= w_place_l;
        end
        if (i_cmd.rd_pos) begin
            r_pos_a <= pos_mem[r_pa];
            r_pos_b <= pos_mem[r_pb];
        end
        if (i_cmd.rd_sq) begin
            r_ch_a <= sq_mem[w_o1];
            r_ch_b <= sq_mem[w_o2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_stat.go_enc) begin
            r_pa <= f_map_j(r_pend);
            if (w_text_pair && w_letter != r_pend) begin
                r_pb <= f_map_j(w_letter);
            end else begin
                r_pb <= pce_pkg::C_IDX_X;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_fill     <= 5'd0;
            r_sealed   <= 1'b0;
            r_seal_idx <= 5'd0;
            r_pend     <= 5'd0;
            r_pend_v   <= 1'b0;
        end else begin
            if (w_place_do) begin
                r_present[w_place_l] <= 1'b1;
                r_fill               <= r_fill + 5'd1;
            end
            if (i_cmd.seal_step) begin
                if (o_stat.seal_last) begin
                    r_seal_idx <= 5'd0;
                    r_sealed   <= 1'b1;
                end else begin
                    r_seal_idx <= r_seal_idx + 5'd1;
                end
            end
            if (i_cmd.take) begin
                if (w_mode == pce_pkg::MODE_TEXT && r_sealed && w_is_letter && !r_pend_v) begin
                    r_pend   <= w_letter;
                    r_pend_v <= 1'b1;
                end else if (w_text_pair && w_letter != r_pend) begin
                    r_pend_v <= 1'b0;
                end else if (w_flush_pair) begin
                    r_pend_v <= 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_pair_last   = i_cmd.out_second;
        o_cipher_char = pce_pkg::C_CHAR_A + {2'b00, (i_cmd.out_second ? r_ch_b : r_ch_a)};
    end

endmodule

`default_nettype wire

>>> src/pce_ctrl.sv
// Controller of the Playfair encryptor: sequences item intake, the seal sweep,
// the two lookup steps and the two output beats. Depends on pce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pce_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    input  wire pce_pkg::t_stat i_stat,
    output pce_pkg::t_cmd    o_cmd
);

    pce_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pce_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.go_seal) begin
                        n_state = pce_pkg::ST_SEAL;
                    end else if (i_stat.go_enc) begin
                        n_state = pce_pkg::ST_POS;
                    end
                end
            end
            pce_pkg::ST_SEAL: begin
                if (i_stat.seal_last) begin
                    n_state = pce_pkg::ST_IDLE;
                end
            end
            pce_pkg::ST_POS:  n_state = pce_pkg::ST_SQ;
            pce_pkg::ST_SQ:   n_state = pce_pkg::ST_OUT_FIRST;
            pce_pkg::ST_OUT_FIRST: begin
                if (i_out_ready) begin
                    n_state = pce_pkg::ST_OUT_SECOND;
                end
            end
            pce_pkg::ST_OUT_SECOND: begin
                if (i_out_ready) begin
                    n_state = pce_pkg::ST_IDLE;
                end
            end
            default: n_state = pce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_out_valid      = 1'b0;
        o_cmd            = '0;
        case (r_state)
            pce_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            pce_pkg::ST_SEAL:  o_cmd.seal_step = 1'b1;
            pce_pkg::ST_POS:   o_cmd.rd_pos = 1'b1;
            pce_pkg::ST_SQ:    o_cmd.rd_sq = 1'b1;
            pce_pkg::ST_OUT_FIRST: begin
                o_out_valid = 1'b1;
            end
            pce_pkg::ST_OUT_SECOND: begin
                o_out_valid      = 1'b1;
                o_cmd.out_second = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> src/playfair_cipher_encryptor_unit.sv
// Playfair encryptor top level: one item at a time. Key and text bytes that
// give no pair are taken in IDLE; a seal runs a 26-letter sweep in ST_SEAL.
// A pair: the input beat, the ST_POS and ST_SQ lookups, then the two letter
// beats, each held while the output is not ready (two lookup steps, two beats).
// Synchronous active-low reset clears control, seal state, present bits, fill
// and pending letter; the square and position memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module playfair_cipher_encryptor_unit (
    input wire        i_clk,
    input wire        i_rst_n,
    pce_in_if.sink    i_in_ch,
    pce_out_if.source o_out_ch
);

    pce_pkg::t_cmd  w_cmd;
    pce_pkg::t_stat w_stat;

    pce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_out_ready (o_out_ch.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pce_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_mode        (i_in_ch.mode),
        .i_data_byte   (i_in_ch.data_byte),
        .o_cipher_char (o_out_ch.cipher_char),
        .o_pair_last   (o_out_ch.pair_last)
    );

endmodule

`default_nettype wire

>>> src/pce_checker.sv
// Port-level checks for the Playfair encryptor and their bind to the top level.
// Depends on playfair_cipher_encryptor_unit and the channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module pce_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [6:0] i_cipher_char,
    input wire       i_pair_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_cipher_char) && $stable(i_pair_last))
        else $error("output beat changed while stalled");

    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_pair_last |=> i_out_valid && i_pair_last)
        else $error("second letter of pair did not follow the first");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while a cipher letter is pending");

    a_letter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_cipher_char >= 7'd65 && i_cipher_char <= 7'd90
            && i_cipher_char != 7'd74)
        else $error("cipher letter out of range");

endmodule

bind playfair_cipher_encryptor_unit pce_checker u_pce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_ch.valid),
    .i_in_ready    (i_in_ch.ready),
    .i_out_valid   (o_out_ch.valid),
    .i_out_ready   (o_out_ch.ready),
    .i_cipher_char (o_out_ch.cipher_char),
    .i_pair_last   (o_out_ch.pair_last)
);

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for the Playfair encryptor: drives key, seal, text and flush beats,
// predicts the cipher letters and checks every output beat in order.
// Depends on pce_pkg, pce_ifs and playfair_cipher_encryptor_unit.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_letter;

    typedef struct packed {
        pce_pkg::t_mode mode;
        logic [7:0]     dat;
        logic           no_out;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    pce_in_if  in_ch();
    pce_out_if out_ch();

    playfair_cipher_encryptor_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // predicted key square and text state
    logic [4:0] sq_cell [25];
    logic [4:0] cell_pos [26];
    logic       letter_in [26];
    int         fill_n;
    bit         sealed;
    logic [4:0] held;
    bit         held_v;

    t_letter cipher_q [$];
    t_letter seen;
    int      err_cnt;
    int      hold_len;
    int      stall_left;
    bit      quiet_tx;
    bit      quiet_rx;

    t_row key_rows [8] = '{
        '{pce_pkg::MODE_KEY, 8'h00, 1'b1},
        '{pce_pkg::MODE_KEY, 8'hFF, 1'b1},
        '{pce_pkg::MODE_KEY, "p",   1'b1},
        '{pce_pkg::MODE_KEY, "L",   1'b1},
        '{pce_pkg::MODE_KEY, "a",   1'b1},
        '{pce_pkg::MODE_KEY, "Y",   1'b1},
        '{pce_pkg::MODE_KEY, "f",   1'b1},
        '{pce_pkg::MODE_KEY, "j",   1'b1}
    };

    // row 0 of the square is P L A Y F and cell 5 holds I
    t_row text_rows [17] = '{
        '{pce_pkg::MODE_SEAL,  8'h00, 1'b1},
        '{pce_pkg::MODE_SEAL,  8'hFF, 1'b1},
        '{pce_pkg::MODE_KEY,   "Q",   1'b1},
        '{pce_pkg::MODE_FLUSH, 8'h00, 1'b1},
        '{pce_pkg::MODE_TEXT,  "p",   1'b0},
        '{pce_pkg::MODE_TEXT,  "l",   1'b0},
        '{pce_pkg::MODE_TEXT,  "P",   1'b0},
        '{pce_pkg::MODE_TEXT,  "i",   1'b0},
        '{pce_pkg::MODE_TEXT,  "e",   1'b0},
        '{pce_pkg::MODE_TEXT,  "E",   1'b0},
        '{pce_pkg::MODE_TEXT,  "J",   1'b0},
        '{pce_pkg::MODE_TEXT,  "j",   1'b0},
        '{pce_pkg::MODE_TEXT,  "i",   1'b0},
        '{pce_pkg::MODE_TEXT,  "x",   1'b0},
        '{pce_pkg::MODE_TEXT,  "X",   1'b0},
        '{pce_pkg::MODE_FLUSH, 8'hA5, 1'b0},
        '{pce_pkg::MODE_TEXT,  "%",   1'b1}
    };

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int letter_idx(logic [7:0] b);
        if (b >= 8'd65 && b <= 8'd90) return int'(b) - 65;
        if (b >= 8'd97 && b <= 8'd122) return int'(b) - 97;
        return -1;
    endfunction

    function automatic void add_to_square(int l);
        if (l == pce_pkg::C_IDX_J) l = pce_pkg::C_IDX_I;
        if (l < 0 || fill_n >= pce_pkg::C_CELLS) return;
        if (letter_in[l]) return;
        letter_in[l] = 1'b1;
        cell_pos[l] = fill_n[4:0];
        sq_cell[fill_n] = l[4:0];
        fill_n++;
    endfunction

    function automatic int cell_of(logic [4:0] l);
        return (l == pce_pkg::C_IDX_J) ? cell_pos[pce_pkg::C_IDX_I] : cell_pos[l];
    endfunction

    function automatic void encipher_pair(logic [4:0] a, logic [4:0] b);
        int      i1, i2, r1, c1, r2, c2, o1, o2;
        t_letter e;
        i1 = cell_of(a);
        i2 = cell_of(b);
        r1 = i1 / 5;
        c1 = i1 % 5;
        r2 = i2 / 5;
        c2 = i2 % 5;
        if (r1 == r2) begin
            o1 = r1 * 5 + (c1 + 1) % 5;
            o2 = r2 * 5 + (c2 + 1) % 5;
        end else if (c1 == c2) begin
            o1 = ((r1 + 1) % 5) * 5 + c1;
            o2 = ((r2 + 1) % 5) * 5 + c2;
        end else begin
            o1 = r1 * 5 + c2;
            o2 = r2 * 5 + c1;
        end
        e.ch   = pce_pkg::C_CHAR_A + sq_cell[o1];
        e.last = 1'b0;
        cipher_q.push_back(e);
        e.ch   = pce_pkg::C_CHAR_A + sq_cell[o2];
        e.last = 1'b1;
        cipher_q.push_back(e);
    endfunction

    function automatic void playfair_step(pce_pkg::t_mode m, logic [7:0] d);
        int l;
        case (m)
            pce_pkg::MODE_KEY: begin
                if (!sealed) add_to_square(letter_idx(d));
            end
            pce_pkg::MODE_SEAL: begin
                if (!sealed) begin
                    for (int k = 0; k < 26; k++)
                        if (k != pce_pkg::C_IDX_J) add_to_square(k);
                    sealed = 1'b1;
                end
            end
            pce_pkg::MODE_TEXT: begin
                l = letter_idx(d);
                if (sealed && l >= 0) begin
                    if (!held_v) begin
                        held   = l[4:0];
                        held_v = 1'b1;
                    end else if (l[4:0] == held) begin
                        encipher_pair(held, pce_pkg::C_IDX_X);
                    end else begin
                        encipher_pair(held, l[4:0]);
                        held_v = 1'b0;
                    end
                end
            end
            default: begin
                if (sealed && held_v) begin
                    encipher_pair(held, pce_pkg::C_IDX_X);
                    held_v = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic logic [7:0] rand_letter();
        logic [7:0] base;
        base = $urandom_range(0, 1) ? 8'd97 : 8'd65;
        return base + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_nonletter();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (letter_idx(b) >= 0);
        return b;
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        $display("%0t ns mismatch on %s: want %0d got %0d", $time, what, want, got);
        err_cnt++;
    endtask

    task automatic send_item(pce_pkg::t_mode m, logic [7:0] d, logic no_out);
        int gap;
        int n0;
        gap = quiet_tx ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.mode      = m;
        in_ch.data_byte = d;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n0 = cipher_q.size();
        playfair_step(m, d);
        // rows with no output typed in: nothing may come out
        if (no_out)
            while (cipher_q.size() > n0) void'(cipher_q.pop_back());
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (cipher_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (cipher_q.size() == 0) begin
                report_mismatch("unexpected cipher beat", 0, out_ch.cipher_char);
            end else begin
                seen = cipher_q.pop_front();
                if (out_ch.cipher_char !== seen.ch)
                    report_mismatch("cipher_char", seen.ch, out_ch.cipher_char);
                if (out_ch.pair_last !== seen.last)
                    report_mismatch("pair_last", seen.last, out_ch.pair_last);
            end
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                out_ch.ready = 1'b0;
                hold_len--;
            end else if (quiet_rx) begin
                out_ch.ready = 1'b1;
            end else begin
                if (stall_left == 0 && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                if (stall_left > 0) begin
                    out_ch.ready = 1'b0;
                    stall_left--;
                end else begin
                    out_ch.ready = 1'b1;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int         counted;
        int         r;
        int         n_key;
        bit         held_off;
        bit         drained;
        logic [7:0] last_txt;
        logic [7:0] d;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = pce_pkg::MODE_KEY;
        in_ch.data_byte = 8'h00;
        err_cnt         = 0;
        hold_len        = 0;
        quiet_tx        = 1'b0;
        quiet_rx        = 1'b0;
        fill_n          = 0;
        sealed          = 1'b0;
        held            = '0;
        held_v          = 1'b0;
        for (int k = 0; k < 26; k++) letter_in[k] = 1'b0;
        counted  = 0;
        held_off = 1'b0;
        drained  = 1'b0;
        last_txt = "A";

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // text before the seal is dropped
        send_item(pce_pkg::MODE_TEXT, "A", 1'b1);
        foreach (key_rows[i])
            send_item(key_rows[i].mode, key_rows[i].dat, key_rows[i].no_out);

        // random tail of the keyword
        n_key = $urandom_range(0, 20);
        repeat (n_key) begin
            d = ($urandom_range(0, 4) != 0) ? rand_letter() : 8'($urandom_range(0, 255));
            send_item(pce_pkg::MODE_KEY, d, 1'b1);
        end

        foreach (text_rows[i])
            send_item(text_rows[i].mode, text_rows[i].dat, text_rows[i].no_out);

        while (counted < 850) begin
            if (counted >= 250 && !held_off) begin
                hold_len = 300;
                held_off = 1'b1;
            end
            if (counted >= 500 && !drained) begin
                wait_drain();
                drained = 1'b1;
            end
            quiet_tx = (counted >= 600 && counted < 700);
            quiet_rx = quiet_tx;

            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_item(pce_pkg::t_mode'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 1'b0);
            end else if (r < 12) begin
                send_item(pce_pkg::MODE_TEXT, rand_nonletter(), 1'b0);
            end else if (r < 20) begin
                send_item(pce_pkg::MODE_FLUSH, 8'($urandom_range(0, 255)), 1'b0);
            end else begin
                if ($urandom_range(0, 99) < 15)
                    d = (last_txt & 8'hDF) | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
                else
                    d = rand_letter();
                last_txt = d;
                send_item(pce_pkg::MODE_TEXT, d, 1'b0);
            end
            counted++;
        end

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        quiet_rx    = 1'b0;
        wait_drain();
        repeat (40) @(posedge i_clk);

        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
